/* rtl/bpdc_pkg.sv */
// Shared types, constants and helper functions for the button/pot DC motor controller.
// No dependencies; every other file in rtl/ imports this package.
`timescale 1ns / 1ps
`default_nettype none

package bpdc_pkg;

  // Fixed field widths
  localparam int unsigned ButtonCount     = 4;
  localparam int unsigned PotBits         = 10;
  localparam int unsigned LevelBits       = 4;
  localparam int unsigned DutyBits        = 8;
  localparam int unsigned NowBits         = 32;
  localparam int unsigned LockoutBits     = 16;
  localparam int unsigned TimeBitsDefault = 32;

  // Speed quantization
  localparam int unsigned LevelDivisor = 113;
  localparam int unsigned LevelMax     = 8;
  localparam int unsigned DutyFull     = 255;

  // Reset values
  localparam logic [LockoutBits-1:0] LockoutReset    = 16'd40;
  localparam logic [LevelBits-1:0]   ShownLevelReset = 4'd15;

  // Button positions in button_levels
  localparam int unsigned BtnRun     = 0;
  localparam int unsigned BtnStop    = 1;
  localparam int unsigned BtnForward = 2;
  localparam int unsigned BtnReverse = 3;

  // APB register map: register i at byte address 4*i
  localparam int unsigned ApbDataBits = 32;
  localparam int unsigned CfgAddrBits = 3;
  localparam logic [0:0]  RegLockout  = 1'b0;

  typedef struct packed {
    logic [PotBits-1:0]     pot_sample;
    logic [ButtonCount-1:0] button_levels;
    logic [NowBits-1:0]     now_ms;
  } item_t;

  typedef struct packed {
    logic                 bridge_a;
    logic                 bridge_b;
    logic [DutyBits-1:0]  duty;
    logic [LevelBits-1:0] speed_level;
    logic                 running;
    logic                 forward;
    logic                 display_changed;
  } result_t;

  // pot / 113 capped at 8: count the thresholds reached
  function automatic logic [LevelBits-1:0] pot_to_level(input logic [PotBits-1:0] pot);
    logic [LevelBits-1:0] level;
    level = '0;
    for (int unsigned k = 1; k <= LevelMax; k++) begin
      if (32'(pot) >= k * LevelDivisor) begin
        level = LevelBits'(k);
      end
    end
    return level;
  endfunction

  // level * 255 / 8, truncated
  function automatic logic [DutyBits-1:0] level_to_duty(input logic [LevelBits-1:0] level);
    logic [11:0] prod;
    prod = 12'(level) * 12'(DutyFull);
    return prod[10:3];
  endfunction

endpackage

`default_nettype wire

/* rtl/bpdc_if.sv */
// Valid/ready channel interfaces for control samples and controller results.
// Depends on bpdc_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface bpdc_sample_if;
  import bpdc_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [PotBits-1:0]     pot_sample;
  logic [ButtonCount-1:0] button_levels;
  logic [NowBits-1:0]     now_ms;

  modport source (output valid, output pot_sample, output button_levels, output now_ms,
                  input ready);
  modport sink   (input valid, input pot_sample, input button_levels, input now_ms,
                  output ready);
endinterface

interface bpdc_result_if;
  import bpdc_pkg::*;

  logic                 valid;
  logic                 ready;
  logic                 bridge_a;
  logic                 bridge_b;
  logic [DutyBits-1:0]  duty;
  logic [LevelBits-1:0] speed_level;
  logic                 running;
  logic                 forward;
  logic                 display_changed;

  modport source (output valid, output bridge_a, output bridge_b, output duty,
                  output speed_level, output running, output forward,
                  output display_changed, input ready);
  modport sink   (input valid, input bridge_a, input bridge_b, input duty,
                  input speed_level, input running, input forward,
                  input display_changed, output ready);
endinterface

`default_nettype wire

/* rtl/bpdc_cfg.sv */
// APB-style register block holding the button lockout time.
// Depends on bpdc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bpdc_cfg (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [bpdc_pkg::CfgAddrBits-1:0] paddr,
  input  wire logic [bpdc_pkg::ApbDataBits-1:0] pwdata,
  output logic      [bpdc_pkg::ApbDataBits-1:0] prdata,
  output logic                                  pready,
  output logic      [bpdc_pkg::LockoutBits-1:0] lockout_o
);
  import bpdc_pkg::*;

  logic [LockoutBits-1:0] lockout_q;
  logic                   wr_en;
  logic                   sel_lockout;

  // register index is the word address
  assign sel_lockout = (paddr[CfgAddrBits-1:CfgAddrBits-1] == RegLockout);
  assign wr_en       = psel & penable & pwrite;
  assign pready      = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lockout_q <= LockoutReset;
    end else if (wr_en && sel_lockout) begin
      lockout_q <= pwdata[LockoutBits-1:0];
    end
  end

  // read back, unmapped addresses read zero
  assign prdata    = sel_lockout ? ApbDataBits'(lockout_q) : '0;
  assign lockout_o = lockout_q;

endmodule

`default_nettype wire

/* rtl/bpdc_core.sv */
// Per-sample control logic: button edge/lockout filter, run/direction state,
// speed quantization, duty lookup and display-change tracking. Depends on bpdc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bpdc_core #(
  parameter int unsigned TimeBits = bpdc_pkg::TimeBitsDefault
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             fire_i,
  input  wire bpdc_pkg::item_t                  item_i,
  input  wire logic [bpdc_pkg::LockoutBits-1:0] lockout_i,
  output bpdc_pkg::result_t                     result_o
);
  import bpdc_pkg::*;

  // state
  logic [ButtonCount-1:0] latched_q, latched_d;
  logic [TimeBits-1:0]    last_q [ButtonCount];
  logic [TimeBits-1:0]    last_d [ButtonCount];
  logic                   enable_q, enable_d;
  logic                   forward_q, forward_d;
  logic [LevelBits-1:0]   shown_level_q;
  logic                   shown_enable_q, shown_forward_q;

  logic [TimeBits-1:0]    now_t;
  logic [TimeBits-1:0]    lockout_t;
  logic [TimeBits-1:0]    elapsed [ButtonCount];
  logic [ButtonCount-1:0] accept;
  logic [LevelBits-1:0]   level;
  logic                   changed;

  assign now_t     = item_i.now_ms[TimeBits-1:0];
  assign lockout_t = TimeBits'(lockout_i);

  // press filter: rising level after more than the lockout since last press
  always_comb begin
    for (int unsigned b = 0; b < ButtonCount; b++) begin
      elapsed[b]   = now_t - last_q[b];
      accept[b]    = item_i.button_levels[b] && !latched_q[b] && (elapsed[b] > lockout_t);
      latched_d[b] = item_i.button_levels[b] && (latched_q[b] || accept[b]);
      last_d[b]    = accept[b] ? now_t : last_q[b];
    end
  end

  // later button of each pair wins
  always_comb begin
    enable_d = enable_q;
    if (accept[BtnRun])  enable_d = 1'b1;
    if (accept[BtnStop]) enable_d = 1'b0;
    forward_d = forward_q;
    if (accept[BtnForward]) forward_d = 1'b1;
    if (accept[BtnReverse]) forward_d = 1'b0;
  end

  assign level   = pot_to_level(item_i.pot_sample);
  assign changed = (level != shown_level_q) || (enable_d != shown_enable_q) ||
                   (forward_d != shown_forward_q);

  // result fields
  always_comb begin
    result_o.bridge_a        = enable_d & forward_d;
    result_o.bridge_b        = enable_d & ~forward_d;
    result_o.duty            = enable_d ? level_to_duty(level) : '0;
    result_o.speed_level     = level;
    result_o.running         = enable_d;
    result_o.forward         = forward_d;
    result_o.display_changed = changed;
  end

  // state update once per accepted item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      latched_q       <= '0;
      enable_q        <= 1'b0;
      forward_q       <= 1'b1;
      shown_level_q   <= ShownLevelReset;
      shown_enable_q  <= 1'b1;
      shown_forward_q <= 1'b1;
      for (int unsigned b = 0; b < ButtonCount; b++) begin
        last_q[b] <= '0;
      end
    end else if (fire_i) begin
      latched_q       <= latched_d;
      enable_q        <= enable_d;
      forward_q       <= forward_d;
      shown_level_q   <= level;
      shown_enable_q  <= enable_d;
      shown_forward_q <= forward_d;
      for (int unsigned b = 0; b < ButtonCount; b++) begin
        last_q[b] <= last_d[b];
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/button_pot_dc_motor_controller_top.sv */
// Path: an accepted sample is held in the input register, passes through the core, and
// its result is held in the result register. Throughput: one sample per cycle unless
// out_if.ready stalls the result register; the single-pass core between the two registers
// sets this. While a result waits, the input register takes one more sample, then stalls.
// Reset (rst_ni, async, active low): stopped, forward, lockout 40 ms, press times zero,
// display marked never shown; both pipeline stages empty.
`timescale 1ns / 1ps
`default_nettype none

module button_pot_dc_motor_controller_top #(
  parameter int unsigned TimeBits = bpdc_pkg::TimeBitsDefault
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  bpdc_sample_if.sink                           in_if,
  bpdc_result_if.source                         out_if,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [bpdc_pkg::CfgAddrBits-1:0] paddr,
  input  wire logic [bpdc_pkg::ApbDataBits-1:0] pwdata,
  output logic      [bpdc_pkg::ApbDataBits-1:0] prdata,
  output logic                                  pready
);
  import bpdc_pkg::*;

  logic                   in_valid_q;
  item_t                  item_q;
  logic                   out_valid_q;
  result_t                res_q;
  result_t                res_d;
  logic                   in_ready;
  logic                   advance;
  logic [LockoutBits-1:0] lockout;

  // configuration registers
  bpdc_cfg u_cfg (
    .clk_i,
    .rst_ni,
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .prdata,
    .pready,
    .lockout_o (lockout)
  );

  // pipeline control
  assign advance  = in_valid_q && (!out_valid_q || out_if.ready);
  assign in_ready = !in_valid_q || advance;
  assign in_if.ready = in_ready;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready) begin
      in_valid_q <= in_if.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_if.valid && in_ready) begin
      item_q.pot_sample    <= in_if.pot_sample;
      item_q.button_levels <= in_if.button_levels;
      item_q.now_ms        <= in_if.now_ms;
    end
  end

  // control core
  bpdc_core #(
    .TimeBits (TimeBits)
  ) u_core (
    .clk_i,
    .rst_ni,
    .fire_i    (advance),
    .item_i    (item_q),
    .lockout_i (lockout),
    .result_o  (res_d)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || out_if.ready) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_if.valid           = out_valid_q;
  assign out_if.bridge_a        = res_q.bridge_a;
  assign out_if.bridge_b        = res_q.bridge_b;
  assign out_if.duty            = res_q.duty;
  assign out_if.speed_level     = res_q.speed_level;
  assign out_if.running         = res_q.running;
  assign out_if.forward         = res_q.forward;
  assign out_if.display_changed = res_q.display_changed;

  // checks
  a_advance_fills_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("result register not loaded after item advanced");

  a_item_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !advance) |=> in_valid_q)
    else $error("waiting item dropped from input register");

  a_bridge_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(res_q.bridge_a && res_q.bridge_b))
    else $error("both bridge legs driven");

  a_duty_stopped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !res_q.running) |-> (res_q.duty == '0))
    else $error("nonzero duty while stopped");

  a_level_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (res_q.speed_level <= LevelBits'(LevelMax)))
    else $error("speed level out of range");

endmodule

`default_nettype wire

/* test/button_pot_dc_motor_controller_top_tb.sv */
// Self-checking testbench for button_pot_dc_motor_controller_top: drives samples and
// lockout writes, predicts every result and checks it field by field.
// Depends on rtl/bpdc_pkg.sv, rtl/bpdc_if.sv and the controller RTL.
`timescale 1ns / 1ps

module button_pot_dc_motor_controller_top_tb;
  import bpdc_pkg::*;

  localparam logic [CfgAddrBits-1:0] LockoutAddr = CfgAddrBits'(4 * RegLockout);
  localparam logic [CfgAddrBits-1:0] UnusedAddr  = CfgAddrBits'(4);
  localparam int unsigned            StallLimit  = 4000;
  localparam int unsigned            SettleCycles = 4;
  localparam int unsigned            IdlePercent  = 33;

  // Predicts controller outputs and holds the ones still owed by the block
  class motor_ctrl_model;
    logic [LockoutBits-1:0] lockout_ms;
    logic [ButtonCount-1:0] latched;
    logic [NowBits-1:0]     last_press_ms [ButtonCount];
    logic                   enable;
    logic                   dir_fwd;
    logic [LevelBits-1:0]   shown_level;
    logic                   shown_enable;
    logic                   shown_dir;
    result_t                pending_outputs [$];
    int unsigned            mismatch_count;

    function new();
      lockout_ms   = LockoutReset;
      latched      = '0;
      foreach (last_press_ms[b]) last_press_ms[b] = '0;
      enable       = 1'b0;
      dir_fwd      = 1'b1;
      shown_level  = ShownLevelReset;
      shown_enable = 1'b1;
      shown_dir    = 1'b1;
      mismatch_count = 0;
    endfunction

    // Rising level past the lockout window; release clears the latch
    function bit press_taken(input bit high, input int unsigned b, input logic [NowBits-1:0] now);
      logic [NowBits-1:0] elapsed;
      if (!high) begin
        latched[b] = 1'b0;
        return 1'b0;
      end
      if (!latched[b]) begin
        elapsed = now - last_press_ms[b];
        if (elapsed > NowBits'(lockout_ms)) begin
          last_press_ms[b] = now;
          latched[b] = 1'b1;
          return 1'b1;
        end
      end
      return 1'b0;
    endfunction

    function void note_sample(input item_t s);
      int unsigned level;
      bit taken [ButtonCount];
      result_t r;
      level = s.pot_sample / LevelDivisor;
      if (level > LevelMax) level = LevelMax;
      for (int unsigned b = 0; b < ButtonCount; b++)
        taken[b] = press_taken(s.button_levels[b], b, s.now_ms);
      // later button of each pair wins
      if (taken[BtnRun])     enable  = 1'b1;
      if (taken[BtnStop])    enable  = 1'b0;
      if (taken[BtnForward]) dir_fwd = 1'b1;
      if (taken[BtnReverse]) dir_fwd = 1'b0;
      r.bridge_a        = enable & dir_fwd;
      r.bridge_b        = enable & ~dir_fwd;
      r.duty            = enable ? DutyBits'((level * DutyFull) / LevelMax) : '0;
      r.speed_level     = LevelBits'(level);
      r.running         = enable;
      r.forward         = dir_fwd;
      r.display_changed = 1'b0;
      if (LevelBits'(level) != shown_level || enable != shown_enable || dir_fwd != shown_dir) begin
        shown_level  = LevelBits'(level);
        shown_enable = enable;
        shown_dir    = dir_fwd;
        r.display_changed = 1'b1;
      end
      pending_outputs.push_back(r);
    endfunction

    function void compare_field(input string name, input int unsigned exp_v,
                                input int unsigned act_v);
      if (exp_v != act_v) begin
        $error("%s: expected %0d, got %0d", name, exp_v, act_v);
        mismatch_count++;
      end
    endfunction

    function void check_result(input result_t got);
      result_t exp_r;
      if (pending_outputs.size() == 0) begin
        $error("result item with no sample outstanding");
        mismatch_count++;
        return;
      end
      exp_r = pending_outputs.pop_front();
      compare_field("bridge_a", exp_r.bridge_a, got.bridge_a);
      compare_field("bridge_b", exp_r.bridge_b, got.bridge_b);
      compare_field("duty", exp_r.duty, got.duty);
      compare_field("speed_level", exp_r.speed_level, got.speed_level);
      compare_field("running", exp_r.running, got.running);
      compare_field("forward", exp_r.forward, got.forward);
      compare_field("display_changed", exp_r.display_changed, got.display_changed);
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic psel;
  logic penable;
  logic pwrite;
  logic [CfgAddrBits-1:0] paddr;
  logic [ApbDataBits-1:0] pwdata;
  logic [ApbDataBits-1:0] prdata;
  logic pready;

  bpdc_sample_if smp_if ();
  bpdc_result_if res_if ();

  button_pot_dc_motor_controller_top dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_if   (smp_if),
    .out_if  (res_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  motor_ctrl_model ctrl_model = new();

  bit                     src_idle_en;
  bit                     snk_idle_en;
  int unsigned            stall_cycles;
  logic [NowBits-1:0]     cur_ms;
  logic [ButtonCount-1:0] held_buttons;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Sink side: random back-pressure, changed at the falling edge
  always @(negedge clk_i) begin
    res_if.ready <= snk_idle_en ? ($urandom_range(99) >= IdlePercent) : 1'b1;
  end

  // Result check at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni && res_if.valid && res_if.ready) begin
      ctrl_model.check_result('{bridge_a: res_if.bridge_a, bridge_b: res_if.bridge_b,
                                duty: res_if.duty, speed_level: res_if.speed_level,
                                running: res_if.running, forward: res_if.forward,
                                display_changed: res_if.display_changed});
    end
  end

  // Watchdog on cycles with no item moving on either side
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((smp_if.valid && smp_if.ready) || (res_if.valid && res_if.ready)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= StallLimit) begin
        $display("button_pot_dc_motor_controller_top: mismatch");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  // One sample item, with a random gap ahead of it
  task automatic send_sample(input item_t s);
    int unsigned gap;
    gap = 0;
    if (src_idle_en) while ($urandom_range(99) < IdlePercent) gap++;
    @(negedge clk_i);
    repeat (gap) begin
      smp_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    smp_if.valid         <= 1'b1;
    smp_if.pot_sample    <= s.pot_sample;
    smp_if.button_levels <= s.button_levels;
    smp_if.now_ms        <= s.now_ms;
    do @(posedge clk_i); while (!smp_if.ready);
    ctrl_model.note_sample(s);
  endtask

  // Stop sending and wait for every owed result
  task automatic drain_outputs();
    @(negedge clk_i);
    smp_if.valid <= 1'b0;
    while (ctrl_model.pending_outputs.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // APB write: setup then access
  task automatic apb_write(input logic [CfgAddrBits-1:0] addr, input logic [ApbDataBits-1:0] data);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (addr == LockoutAddr) ctrl_model.lockout_ms = data[LockoutBits-1:0];
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic send_directed(input int unsigned pot, input logic [ButtonCount-1:0] btn,
                               input logic [NowBits-1:0] now);
    send_sample('{pot_sample: PotBits'(pot), button_levels: btn, now_ms: now});
  endtask

  // Mostly held-button sequences over advancing time, some noise items
  task automatic send_random(input int unsigned count);
    item_t s;
    int unsigned step_max;
    for (int unsigned i = 0; i < count; i++) begin
      step_max = ctrl_model.lockout_ms / 4 + 3;
      if ($urandom_range(99) < 85) begin
        cur_ms = cur_ms + $urandom_range(step_max);
        for (int unsigned b = 0; b < ButtonCount; b++)
          if ($urandom_range(99) < 20) held_buttons[b] = ~held_buttons[b];
        s.now_ms        = cur_ms;
        s.button_levels = held_buttons;
      end else begin
        s.now_ms        = $urandom();
        s.button_levels = ButtonCount'($urandom_range(15));
      end
      case ($urandom_range(9))
        0:       s.pot_sample = '0;
        1:       s.pot_sample = '1;
        default: s.pot_sample = PotBits'($urandom_range(1023));
      endcase
      send_sample(s);
    end
  endtask

  initial begin
    logic [LockoutBits-1:0] phase_lockout [7];
    src_idle_en = 1'b1;
    snk_idle_en = 1'b1;
    stall_cycles = 0;
    cur_ms = '0;
    held_buttons = '0;
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    smp_if.valid = 1'b0;
    smp_if.pot_sample = '0;
    smp_if.button_levels = '0;
    smp_if.now_ms = '0;
    res_if.ready = 1'b0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: lockout edges, each button, release, combos, timestamp wrap
    send_directed(0, 4'b0001, 32'd10);      // run held inside reset lockout
    send_directed(1023, 4'b0001, 32'd40);   // elapsed equals lockout: still blocked
    send_directed(1023, 4'b0001, 32'd41);   // accepted while held
    send_directed(112, 4'b0001, 32'd42);    // latched, no repeat
    send_directed(113, 4'b0000, 32'd43);    // release clears latch
    send_directed(904, 4'b1000, 32'd100);   // reverse
    send_directed(903, 4'b0000, 32'd101);
    send_directed(565, 4'b0100, 32'd200);   // forward
    send_directed(565, 4'b0000, 32'd201);
    send_directed(800, 4'b0010, 32'd300);   // stop
    send_directed(800, 4'b0000, 32'd301);
    send_directed(1023, 4'b1111, 32'd400);  // all at once: stop and reverse win
    send_directed(1023, 4'b0000, 32'd401);
    send_directed(339, 4'b0101, 32'd500);   // run and forward
    send_directed(339, 4'b0000, 32'd501);
    send_directed(1023, 4'b1011, 32'hFFFF_FFF0);  // run, stop and reverse presses just before the wrap
    send_directed(0, 4'b0000, 32'hFFFF_FFF1);
    send_directed(512, 4'b0001, 32'h0000_0005);  // across the wrap, inside lockout
    send_directed(512, 4'b0001, 32'h0000_0020);  // still held, now past lockout
    send_directed(1023, 4'b0000, 32'h0000_0021);
    cur_ms = 32'h0000_0021;

    // Random phases, each at its own lockout
    phase_lockout = '{16'd0, 16'hFFFF, 16'd40, LockoutBits'($urandom()), 16'd1,
                      LockoutBits'($urandom_range(200)), 16'd1000};
    for (int unsigned p = 0; p < 7; p++) begin
      drain_outputs();
      apb_write(LockoutAddr, ApbDataBits'(phase_lockout[p]));
      if (p == 4) apb_write(UnusedAddr, $urandom());
      if (p == 2) cur_ms = 32'hFFFF_FE00;
      src_idle_en = (p != 3);
      snk_idle_en = (p != 3);
      send_random(250);
    end

    drain_outputs();
    repeat (8) @(posedge clk_i);
    if (ctrl_model.mismatch_count == 0 && ctrl_model.pending_outputs.size() == 0) begin
      $display("button_pot_dc_motor_controller_top: match");
    end else begin
      $display("button_pot_dc_motor_controller_top: mismatch");
    end
    $finish;
  end

endmodule
